FILE: rtl/spg_pkg.sv
// Switch press gesture detector: shared types, codes and constants.
// No dependencies.
`default_nettype none

package spg_pkg;

    localparam int SWITCH_COUNT = 4;
    localparam int MAX_EVENTS   = 4;
    localparam int SW_W         = 2;
    localparam int ADDR_W       = 3;

    localparam logic [1:0] FUNC_PRESS   = 2'd0;
    localparam logic [1:0] FUNC_RELEASE = 2'd1;
    localparam logic [1:0] FUNC_TICK    = 2'd2;

    localparam logic [2:0] EV_INITIAL    = 3'd0;
    localparam logic [2:0] EV_LONG       = 3'd1;
    localparam logic [2:0] EV_SHORT_REL  = 3'd2;
    localparam logic [2:0] EV_LONG_REL   = 3'd3;
    localparam logic [2:0] EV_MULTI_ON   = 3'd4;
    localparam logic [2:0] EV_MULTI_DONE = 3'd5;

    localparam logic [15:0] LONG_TICKS_RESET   = 16'd5000;
    localparam logic [15:0] WINDOW_TICKS_RESET = 16'd500;

    localparam logic [ADDR_W-1:0] REG_LONG_ADDR   = 3'd0;
    localparam logic [ADDR_W-1:0] REG_WINDOW_ADDR = 3'd4;

    typedef struct packed {
        logic [SW_W-1:0] sw;
        logic [2:0]      code;
        logic [7:0]      count;
    } spg_event_t;

    typedef struct packed {
        spg_event_t [MAX_EVENTS-1:0] ev;
        logic [2:0]                  num;
        logic                        ind;
    } spg_batch_t;

endpackage

`default_nettype wire

FILE: rtl/spg_cfg.sv
// Switch press gesture detector: APB register file for the two timer loads.
// Depends on spg_pkg.
`default_nettype none

module spg_cfg
    import spg_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    output logic [15:0]            long_ticks,
    output logic [15:0]            window_ticks
);

    logic [15:0] long_ticks_reg;
    logic [15:0] window_ticks_reg;
    logic [15:0] wval;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign wval   = (pwdata[15:0] == 16'd0) ? 16'd1 : pwdata[15:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_ticks_reg   <= LONG_TICKS_RESET;
            window_ticks_reg <= WINDOW_TICKS_RESET;
        end
        else if (wr_en)
        begin
            // low address bits ignored: word decode only
            if (paddr[2] == REG_WINDOW_ADDR[2])
            begin
                window_ticks_reg <= wval;
            end
            else
            begin
                long_ticks_reg <= wval;
            end
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_WINDOW_ADDR[2])
        begin
            prdata = {16'd0, window_ticks_reg};
        end
        else
        begin
            prdata = {16'd0, long_ticks_reg};
        end
    end

    assign long_ticks   = long_ticks_reg;
    assign window_ticks = window_ticks_reg;

endmodule

`default_nettype wire

FILE: rtl/spg_core.sv
// Switch press gesture detector: input register, per-switch gesture state
// and timers, and event generation for one item. Depends on spg_pkg.
`default_nettype none

module spg_core
    import spg_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire logic [1:0]      func,
    input  wire logic [SW_W-1:0] switch_index,
    input  wire logic [15:0]     long_ticks,
    input  wire logic [15:0]     window_ticks,
    input  wire logic            buf_free,
    output logic                 batch_load,
    output spg_batch_t           batch
);

    logic                    ivalid_reg;
    logic [1:0]              func_reg;
    logic [SW_W-1:0]         sw_reg;

    logic [SWITCH_COUNT-1:0] held_reg, held_next;
    logic [SWITCH_COUNT-1:0] sent_reg, sent_next;
    logic [SWITCH_COUNT-1:0] open_reg, open_next;
    logic [7:0]              count_reg  [SWITCH_COUNT];
    logic [7:0]              count_next [SWITCH_COUNT];
    logic [15:0]             long_reg   [SWITCH_COUNT];
    logic [15:0]             long_next  [SWITCH_COUNT];
    logic [15:0]             win_reg    [SWITCH_COUNT];
    logic [15:0]             win_next   [SWITCH_COUNT];

    logic                    fire;
    logic [7:0]              inc_count;

    assign fire       = ivalid_reg && buf_free;
    assign in_ready   = !ivalid_reg || buf_free;
    assign batch_load = fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ivalid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            ivalid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            func_reg <= func;
            sw_reg   <= switch_index;
        end
    end

    always_comb
    begin
        inc_count = (count_reg[sw_reg] != 8'd255) ? count_reg[sw_reg] + 8'd1
                                                  : count_reg[sw_reg];
        held_next = held_reg;
        sent_next = sent_reg;
        open_next = open_reg;
        for (int i = 0; i < SWITCH_COUNT; i++)
        begin
            count_next[i] = count_reg[i];
            long_next[i]  = long_reg[i];
            win_next[i]   = win_reg[i];
        end
        for (int k = 0; k < MAX_EVENTS; k++)
        begin
            batch.ev[k] = '0;
        end
        batch.num = 3'd0;

        case (func_reg)
            FUNC_PRESS:
            begin
                held_next[sw_reg]    = 1'b1;
                batch.ev[0].sw       = sw_reg;
                batch.ev[0].code     = EV_INITIAL;
                if (open_reg[sw_reg])
                begin
                    win_next[sw_reg]   = 16'd0;
                    count_next[sw_reg] = inc_count;
                    batch.ev[1].sw     = sw_reg;
                    batch.ev[1].code   = EV_MULTI_ON;
                    batch.ev[1].count  = inc_count;
                    batch.num          = 3'd2;
                end
                else
                begin
                    long_next[sw_reg] = long_ticks;
                    batch.num         = 3'd1;
                end
            end
            FUNC_RELEASE:
            begin
                held_next[sw_reg] = 1'b0;
                long_next[sw_reg] = 16'd0;
                batch.ev[0].sw    = sw_reg;
                batch.num         = 3'd1;
                if (sent_reg[sw_reg])
                begin
                    sent_next[sw_reg]  = 1'b0;
                    win_next[sw_reg]   = 16'd0;
                    open_next[sw_reg]  = 1'b0;
                    count_next[sw_reg] = 8'd0;
                    batch.ev[0].code   = EV_LONG_REL;
                end
                else
                begin
                    batch.ev[0].code = EV_SHORT_REL;
                    if (!open_reg[sw_reg])
                    begin
                        count_next[sw_reg] = 8'd1;
                    end
                    open_next[sw_reg] = 1'b1;
                    win_next[sw_reg]  = window_ticks;
                end
            end
            FUNC_TICK:
            begin
                // scan low switch first, long timer before window timer
                for (int i = 0; i < SWITCH_COUNT; i++)
                begin
                    if (long_reg[i] != 16'd0)
                    begin
                        long_next[i] = long_reg[i] - 16'd1;
                        if (long_reg[i] == 16'd1 && held_reg[i] && !sent_reg[i]
                            && !open_reg[i])
                        begin
                            sent_next[i] = 1'b1;
                            if (batch.num < 3'(MAX_EVENTS))
                            begin
                                batch.ev[batch.num[1:0]].sw    = SW_W'(i);
                                batch.ev[batch.num[1:0]].code  = EV_LONG;
                                batch.ev[batch.num[1:0]].count = 8'd0;
                                batch.num = batch.num + 3'd1;
                            end
                        end
                    end
                    if (win_reg[i] != 16'd0)
                    begin
                        win_next[i] = win_reg[i] - 16'd1;
                        if (win_reg[i] == 16'd1)
                        begin
                            open_next[i]  = 1'b0;
                            count_next[i] = 8'd0;
                            if (batch.num < 3'(MAX_EVENTS))
                            begin
                                batch.ev[batch.num[1:0]].sw    = SW_W'(i);
                                batch.ev[batch.num[1:0]].code  = EV_MULTI_DONE;
                                batch.ev[batch.num[1:0]].count =
                                    (count_reg[i] != 8'd0) ? count_reg[i] : 8'd1;
                                batch.num = batch.num + 3'd1;
                            end
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase

        batch.ind = |held_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
            sent_reg <= '0;
            open_reg <= '0;
            for (int i = 0; i < SWITCH_COUNT; i++)
            begin
                count_reg[i] <= 8'd0;
                long_reg[i]  <= 16'd0;
                win_reg[i]   <= 16'd0;
            end
        end
        else if (fire)
        begin
            held_reg <= held_next;
            sent_reg <= sent_next;
            open_reg <= open_next;
            for (int i = 0; i < SWITCH_COUNT; i++)
            begin
                count_reg[i] <= count_next[i];
                long_reg[i]  <= long_next[i];
                win_reg[i]   <= win_next[i];
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/spg_outbuf.sv
// Switch press gesture detector: result buffer of one item's events, handed
// out one beat per cycle while out_ready is high. Depends on spg_pkg.
`default_nettype none

module spg_outbuf
    import spg_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            batch_load,
    input  wire spg_batch_t      batch,
    output logic                 buf_free,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output logic [SW_W-1:0]      switch_number,
    output logic [2:0]           event_code,
    output logic [7:0]           press_count,
    output logic                 indicator_on,
    output logic                 last_of_run
);

    spg_event_t       ev_reg [MAX_EVENTS];
    logic [2:0]       num_reg;
    logic [1:0]       idx_reg;
    logic             ind_reg;
    logic             last;

    assign out_valid = (num_reg != 3'd0);
    assign last      = ({1'b0, idx_reg} == (num_reg - 3'd1));
    assign buf_free  = !out_valid || (out_ready && last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_reg <= 3'd0;
            idx_reg <= 2'd0;
        end
        else if (batch_load)
        begin
            num_reg <= batch.num;
            idx_reg <= 2'd0;
        end
        else if (out_valid && out_ready)
        begin
            if (last)
            begin
                num_reg <= 3'd0;
                idx_reg <= 2'd0;
            end
            else
            begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (batch_load)
        begin
            for (int k = 0; k < MAX_EVENTS; k++)
            begin
                ev_reg[k] <= batch.ev[k];
            end
            ind_reg <= batch.ind;
        end
    end

    assign switch_number = ev_reg[idx_reg].sw;
    assign event_code    = ev_reg[idx_reg].code;
    assign press_count   = ev_reg[idx_reg].count;
    assign indicator_on  = ind_reg;
    assign last_of_run   = last;

endmodule

`default_nettype wire

FILE: rtl/switch_press_gesture_detector_unit.sv
// An accepted beat waits in the core's input register until the result
// buffer is free, then loads its events there; they are handed out one per
// cycle while out_ready is high. A new item is taken while the buffer still
// holds the last events; it waits until the last of them is taken.
// Reset: rst_n asynchronous, active low; all gesture state and timers clear,
// timer registers load 5000 and 500.
`default_nettype none

module switch_press_gesture_detector_unit
    import spg_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [1:0]        func,
    input  wire logic [SW_W-1:0]   switch_index,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [SW_W-1:0]        switch_number,
    output logic [2:0]             event_code,
    output logic [7:0]             press_count,
    output logic                   indicator_on,
    output logic                   last_of_run
);

    logic [15:0] long_ticks;
    logic [15:0] window_ticks;
    logic        buf_free;
    logic        batch_load;
    spg_batch_t  batch;

    spg_cfg u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .long_ticks   (long_ticks),
        .window_ticks (window_ticks)
    );

    spg_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .switch_index (switch_index),
        .long_ticks   (long_ticks),
        .window_ticks (window_ticks),
        .buf_free     (buf_free),
        .batch_load   (batch_load),
        .batch        (batch)
    );

    spg_outbuf u_outbuf (
        .clk           (clk),
        .rst_n         (rst_n),
        .batch_load    (batch_load),
        .batch         (batch),
        .buf_free      (buf_free),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .switch_number (switch_number),
        .event_code    (event_code),
        .press_count   (press_count),
        .indicator_on  (indicator_on),
        .last_of_run   (last_of_run)
    );

endmodule

`default_nettype wire

FILE: rtl/spg_checker.sv
// Switch press gesture detector: port-level checker and its bind to the top.
// Depends on spg_pkg.
`default_nettype none

module spg_checker
    import spg_pkg::*;
(
    input wire logic            clk,
    input wire logic            rst_n,
    input wire logic            out_valid,
    input wire logic            out_ready,
    input wire logic [SW_W-1:0] switch_number,
    input wire logic [2:0]      event_code,
    input wire logic [7:0]      press_count,
    input wire logic            last_of_run
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(event_code)
            && $stable(switch_number) && $stable(press_count))
        else $error("result beat changed while stalled");

    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> event_code <= EV_MULTI_DONE)
        else $error("undefined event code");

    a_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_code != EV_MULTI_ON && event_code != EV_MULTI_DONE
            |-> press_count == 8'd0)
        else $error("count on event without count");

    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_code == EV_MULTI_ON || event_code == EV_MULTI_DONE)
            |-> press_count != 8'd0)
        else $error("multi-press event with zero count");

    a_multi_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_code == EV_MULTI_ON |-> last_of_run)
        else $error("multi ongoing not last of its run");

endmodule

bind switch_press_gesture_detector_unit spg_checker u_spg_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .switch_number (switch_number),
    .event_code    (event_code),
    .press_count   (press_count),
    .last_of_run   (last_of_run)
);

`default_nettype wire
